@@ sv/gbi_pkg.sv @@
// Shared types and constants of the grid bilinear interpolator.
package gbi_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int IDX_IN_W  = 6;
    localparam int CFG_IDX_W = 2;
    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 32;

    localparam logic [DATA_W-1:0] SCALE_RESET = 32'h003F_0000;
    localparam logic [FRAC_W:0]   FRAC_ONE    = 17'h1_0000;

    typedef enum logic [0:0]
    {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_X_ORIGIN = 2'd0,
        CFG_X_SCALE  = 2'd1,
        CFG_Y_ORIGIN = 2'd2,
        CFG_Y_SCALE  = 2'd3
    } cfg_reg_t;

endpackage

@@ sv/gbi_bank.sv @@
// One bank of the sample grid: one write port, one registered read port.
module gbi_bank #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [gbi_pkg::DATA_W-1:0] wdata,
    input  logic                      re,
    input  logic [AW-1:0]             raddr,
    output logic [gbi_pkg::DATA_W-1:0] rdata
);
    import gbi_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/gbi_locate.sv @@
// Maps one Q16.16 coordinate to a grid index and a 16-bit fraction in four stages.
module gbi_locate #(
    parameter int NUM = 64
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [gbi_pkg::DATA_W-1:0] coord,
    input  logic [gbi_pkg::DATA_W-1:0] origin,
    input  logic [gbi_pkg::DATA_W-1:0] scale,
    output logic [$clog2(NUM)-1:0]     idx,
    output logic [gbi_pkg::FRAC_W-1:0] frac,
    output logic                       clamp
);
    import gbi_pkg::*;

    localparam int IW = $clog2(NUM);
    localparam logic [DATA_W-1:0] LAST = 32'(NUM - 1);

    logic [DATA_W:0]     diff_next, diff_reg;
    logic [DATA_W:0]     mag_next, mag_reg;
    logic                neg2_reg, neg3_reg;
    logic [2*DATA_W:0]   prod_full;
    logic [2*DATA_W-1:0] prod_next, prod_reg;
    logic [DATA_W-1:0]   ipart;
    logic [IW-1:0]       idx_next, idx_reg;
    logic [FRAC_W-1:0]   frac_next, frac_reg;
    logic                clamp_next, clamp_reg;

    always_comb
    begin
        diff_next = {coord[DATA_W-1], coord} - {origin[DATA_W-1], origin};
        // Magnitude reaches 2^32 - 1 at most, which still fits the 33-bit register.
        mag_next  = diff_reg[DATA_W] ? (~diff_reg + 33'd1) : diff_reg;
        prod_full = 65'(mag_reg) * 65'(scale);
        prod_next = prod_full[2*DATA_W-1:0];
        ipart     = prod_reg[2*DATA_W-1:DATA_W];

        if (neg3_reg && (prod_reg != '0))
        begin
            idx_next   = '0;
            frac_next  = '0;
            clamp_next = 1'b1;
        end
        else if (ipart >= LAST)
        begin
            // Landing exactly on the last index is not a clamp.
            idx_next   = IW'(NUM - 1);
            frac_next  = '0;
            clamp_next = (ipart != LAST) || (prod_reg[DATA_W-1:0] != '0);
        end
        else
        begin
            idx_next   = ipart[IW-1:0];
            frac_next  = prod_reg[DATA_W-1:DATA_W-FRAC_W];
            clamp_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg  <= diff_next;
            mag_reg   <= mag_next;
            neg2_reg  <= diff_reg[DATA_W];
            prod_reg  <= prod_next;
            neg3_reg  <= neg2_reg;
            idx_reg   <= idx_next;
            frac_reg  <= frac_next;
            clamp_reg <= clamp_next;
        end
    end

    assign idx   = idx_reg;
    assign frac  = frac_reg;
    assign clamp = clamp_reg;

endmodule

@@ sv/grid_bilinear_interpolator.sv @@
// Grid bilinear interpolator: a ROWS by COLS table of Q16.16 samples with bilinear lookup.
//
// Input stream s_axis: tuser carries the command. A write request stores entry_value at
// (row_index, col_index) and returns nothing; writes outside the grid are dropped. A query
// request maps (x_coord, y_coord) through the origin and scale registers and returns one
// result on m_axis: the blended sample in tdata and the clamp flag in tuser.
// The cfg channel writes the four origin and scale registers; it is always ready and must
// only be used while no request is in flight.
// One request is accepted every cycle while the output is not stalled. The grid sits
// in four banks split by row and column parity, so the four neighbours of a query are
// read in the same cycle from one read port per bank. Writes reach the banks at the
// same stage as query reads, which keeps requests in order.
// Reset clears the valid pipeline and loads the register defaults; the grid itself holds
// no reset value and each entry must be written before a query uses it.
// When m_axis_tready is low with a result waiting, the whole pipeline holds and
// s_axis_tready drops until the result is taken.
module grid_bilinear_interpolator #(
    parameter int ROWS = 64,
    parameter int COLS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // row_index[5:0], col_index[11:6], entry_value[43:12], x_coord[75:44], y_coord[107:76]
    input  logic [gbi_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // cmd[0]
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // interp_value[31:0]
    output logic [gbi_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // clamped[0]
    output logic                             m_axis_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gbi_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gbi_pkg::DATA_W-1:0]       cfg_data
);
    import gbi_pkg::*;

    localparam int RW     = $clog2(ROWS);
    localparam int CW     = $clog2(COLS);
    localparam int HR     = (ROWS + 1) / 2;
    localparam int HC     = (COLS + 1) / 2;
    localparam int BDEPTH = HR * HC;
    localparam int AW     = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
    localparam int WW     = 2 * FRAC_W + 1;
    localparam int PW     = WW + DATA_W;
    localparam int SW     = PW + 2;

    localparam int ROW_LO = 0;
    localparam int COL_LO = ROW_LO + IDX_IN_W;
    localparam int VAL_LO = COL_LO + IDX_IN_W;
    localparam int X_LO   = VAL_LO + DATA_W;
    localparam int Y_LO   = X_LO + DATA_W;

    localparam logic signed [SW-1:0] ROUND_HALF = SW'(64'sh8000_0000);

    // Configuration registers.
    logic [DATA_W-1:0] x_origin_reg, x_scale_reg, y_origin_reg, y_scale_reg;

    // Pipeline control.
    logic        adv;
    logic [8:1]  qv_reg;
    logic [4:1]  wv_reg;
    logic        out_valid_reg;

    // Write fields delayed to the bank stage.
    logic [IDX_IN_W-1:0] wrow_reg [1:4];
    logic [IDX_IN_W-1:0] wcol_reg [1:4];
    logic [DATA_W-1:0]   wval_reg [1:4];

    // Locate results at stage 4.
    logic [RW-1:0]     ix, ix1;
    logic [CW-1:0]     iy, iy1;
    logic [FRAC_W-1:0] fx, fy;
    logic              cx, cy;

    // Bank access.
    logic [RW-1:0]     rsel [2];
    logic [CW-1:0]     csel [2];
    logic [AW-1:0]     raddr [4];
    logic [DATA_W-1:0] rdata [4];
    logic              wr_en;
    logic              wr_in_range;
    logic [1:0]        wr_bank;
    logic [AW-1:0]     wr_addr;

    // Stage 5 to stage 8 payload.
    logic              pa_reg, pb_reg, qa_reg, qb_reg;
    logic [FRAC_W-1:0] fx5_reg, fy5_reg;
    logic [8:5]        cl_reg;
    logic [FRAC_W:0]   wx0, wy0;
    logic [WW:0]       wprod [4];
    logic [WW-1:0]     w_reg [4];
    logic signed [DATA_W-1:0] v_reg [4];
    logic signed [PW-1:0]     p_reg [4];
    logic signed [PW:0]       sa_reg, sb_reg;
    logic signed [SW-1:0]     total;
    logic [DATA_W-1:0]        out_data_reg;
    logic                     out_clamp_reg;

    assign cfg_ready     = 1'b1;
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_origin_reg <= '0;
            x_scale_reg  <= SCALE_RESET;
            y_origin_reg <= '0;
            y_scale_reg  <= SCALE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_X_ORIGIN: x_origin_reg <= cfg_data;
                CFG_X_SCALE:  x_scale_reg  <= cfg_data;
                CFG_Y_ORIGIN: y_origin_reg <= cfg_data;
                CFG_Y_SCALE:  y_scale_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qv_reg        <= '0;
            wv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            qv_reg        <= {qv_reg[7:1],
                              s_axis_tvalid && (cmd_t'(s_axis_tuser) == CMD_QUERY)};
            wv_reg        <= {wv_reg[3:1],
                              s_axis_tvalid && (cmd_t'(s_axis_tuser) == CMD_WRITE)};
            out_valid_reg <= qv_reg[8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wrow_reg[1] <= s_axis_tdata[COL_LO-1:ROW_LO];
            wcol_reg[1] <= s_axis_tdata[VAL_LO-1:COL_LO];
            wval_reg[1] <= s_axis_tdata[X_LO-1:VAL_LO];
            for (int k = 2; k <= 4; k++)
            begin
                wrow_reg[k] <= wrow_reg[k-1];
                wcol_reg[k] <= wcol_reg[k-1];
                wval_reg[k] <= wval_reg[k-1];
            end
        end
    end

    gbi_locate #(.NUM(ROWS)) u_loc_x (
        .clk    (clk),
        .en     (adv),
        .coord  (s_axis_tdata[Y_LO-1:X_LO]),
        .origin (x_origin_reg),
        .scale  (x_scale_reg),
        .idx    (ix),
        .frac   (fx),
        .clamp  (cx)
    );

    gbi_locate #(.NUM(COLS)) u_loc_y (
        .clk    (clk),
        .en     (adv),
        .coord  (s_axis_tdata[Y_LO+DATA_W-1:Y_LO]),
        .origin (y_origin_reg),
        .scale  (y_scale_reg),
        .idx    (iy),
        .frac   (fy),
        .clamp  (cy)
    );

    // Each bank row parity reads whichever of the two needed rows has that parity. On the
    // last row both rows are the same, and both picks below take the same bank.
    always_comb
    begin
        ix1 = (ix == RW'(ROWS - 1)) ? ix : ix + RW'(1);
        iy1 = (iy == CW'(COLS - 1)) ? iy : iy + CW'(1);
        for (int p = 0; p < 2; p++)
        begin
            rsel[p] = (ix[0] == p[0]) ? ix : ix1;
            csel[p] = (iy[0] == p[0]) ? iy : iy1;
        end
        for (int b = 0; b < 4; b++)
        begin
            raddr[b] = AW'(32'(rsel[b / 2] >> 1) * HC + 32'(csel[b % 2] >> 1));
        end

        wr_in_range = (32'(wrow_reg[4]) < 32'(ROWS)) && (32'(wcol_reg[4]) < 32'(COLS));
        wr_en       = adv && wv_reg[4] && wr_in_range;
        wr_bank     = {wrow_reg[4][0], wcol_reg[4][0]};
        wr_addr     = AW'(32'(wrow_reg[4] >> 1) * HC + 32'(wcol_reg[4] >> 1));
    end

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        gbi_bank #(.DEPTH(BDEPTH), .AW(AW)) u_bank (
            .clk   (clk),
            .we    (wr_en && (wr_bank == 2'(b))),
            .waddr (wr_addr),
            .wdata (wval_reg[4]),
            .re    (adv),
            .raddr (raddr[b]),
            .rdata (rdata[b])
        );
    end

    always_comb
    begin
        wx0      = FRAC_ONE - {1'b0, fx5_reg};
        wy0      = FRAC_ONE - {1'b0, fy5_reg};
        wprod[0] = 34'(wx0) * 34'(wy0);
        wprod[1] = 34'(wx0) * 34'(fy5_reg);
        wprod[2] = 34'(fx5_reg) * 34'(wy0);
        wprod[3] = 34'(fx5_reg) * 34'(fy5_reg);
        total    = SW'(sa_reg) + SW'(sb_reg) + ROUND_HALF;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_reg  <= ix[0];
            pb_reg  <= ix1[0];
            qa_reg  <= iy[0];
            qb_reg  <= iy1[0];
            fx5_reg <= fx;
            fy5_reg <= fy;
            cl_reg  <= {cl_reg[7:5], cx || cy};

            v_reg[0] <= rdata[{pa_reg, qa_reg}];
            v_reg[1] <= rdata[{pa_reg, qb_reg}];
            v_reg[2] <= rdata[{pb_reg, qa_reg}];
            v_reg[3] <= rdata[{pb_reg, qb_reg}];
            for (int k = 0; k < 4; k++)
            begin
                w_reg[k] <= wprod[k][WW-1:0];
                p_reg[k] <= $signed({1'b0, w_reg[k]}) * v_reg[k];
            end

            sa_reg <= (PW+1)'(p_reg[0]) + (PW+1)'(p_reg[1]);
            sb_reg <= (PW+1)'(p_reg[2]) + (PW+1)'(p_reg[3]);

            out_data_reg  <= total[2*DATA_W-1:DATA_W];
            out_clamp_reg <= cl_reg[8];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_clamp_reg;

endmodule

@@ sv/gbi_checker.sv @@
// Port-level checks for the grid bilinear interpolator and their bind.
module gbi_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [gbi_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                          m_axis_tuser,
    input logic                          cfg_valid,
    input logic                          cfg_ready
);
    import gbi_pkg::*;

    // A held result keeps its payload until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Requests are taken whenever the output register is free or draining.
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
        else $error("request refused with a free output");

    // Reset empties the output by the following edge.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("result valid during reset");

    // Register writes are never back-pressured.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind grid_bilinear_interpolator gbi_checker u_gbi_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready)
);

@@ tb/tb_top.sv @@
// Self-checking testbench for the grid bilinear interpolator.
`timescale 1ns / 1ps

module tb_top;
    import gbi_pkg::*;

    localparam int GRID_ROWS     = 64;
    localparam int GRID_COLS     = 64;
    localparam int LATENCY       = 9;
    localparam int SETTLE_CYCLES = 2 * LATENCY;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int PHASES        = 6;
    localparam int ITEMS_PER_PHASE = 205;
    localparam longint COORD_MIN = -64'sd2147483648;
    localparam longint COORD_MAX = 64'sd2147483647;

    typedef struct packed
    {
        logic [DATA_W-1:0] value;
        logic              clamped;
    } interp_result_t;

    class interp_scoreboard;
        logic [DATA_W-1:0] grid [GRID_ROWS*GRID_COLS];
        logic [DATA_W-1:0] x_origin;
        logic [DATA_W-1:0] x_scale;
        logic [DATA_W-1:0] y_origin;
        logic [DATA_W-1:0] y_scale;
        interp_result_t    pending_q[$];
        int                errors;

        function new();
            x_origin = '0;
            x_scale  = SCALE_RESET;
            y_origin = '0;
            y_scale  = SCALE_RESET;
            errors   = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [DATA_W-1:0] value);
            case (idx)
                CFG_X_ORIGIN: x_origin = value;
                CFG_X_SCALE:  x_scale  = value;
                CFG_Y_ORIGIN: y_origin = value;
                CFG_Y_SCALE:  y_scale  = value;
                default: ;
            endcase
        endfunction

        // Grid position is the exact Q32.32 product (coord - origin) * scale.
        function bit map_coord(input logic [DATA_W-1:0] coord, input logic [DATA_W-1:0] origin,
                               input logic [DATA_W-1:0] scale, input int last,
                               output int idx, output int frac);
            longint          diff;
            longint unsigned mag;
            longint unsigned sc;
            longint unsigned prod;
            longint unsigned top;
            diff = longint'($signed(coord)) - longint'($signed(origin));
            mag  = (diff < 0) ? -diff : diff;
            sc   = scale;
            prod = mag * sc;
            top  = last;
            top  = top << 32;
            if (diff < 0 && prod != 0)
            begin
                idx  = 0;
                frac = 0;
                return 1'b1;
            end
            if (prod >= top)
            begin
                idx  = last;
                frac = 0;
                return prod > top;
            end
            idx  = int'(prod >> 32);
            frac = int'((prod >> 16) & 64'hFFFF);
            return 1'b0;
        endfunction

        function longint sample_at(int r, int c);
            return longint'($signed(grid[r*GRID_COLS+c]));
        endfunction

        function void note_request(cmd_t cmd, logic [IDX_IN_W-1:0] row, logic [IDX_IN_W-1:0] col,
                                   logic [DATA_W-1:0] entry, logic [DATA_W-1:0] xc,
                                   logic [DATA_W-1:0] yc);
            int             ix, iy, fx, fy, ix1, iy1;
            bit             cx, cy;
            longint         near_row, far_row, blend;
            interp_result_t res;
            if (cmd == CMD_WRITE)
            begin
                if (row < GRID_ROWS && col < GRID_COLS)
                    grid[row*GRID_COLS+col] = entry;
                return;
            end
            cx  = map_coord(xc, x_origin, x_scale, GRID_ROWS - 1, ix, fx);
            cy  = map_coord(yc, y_origin, y_scale, GRID_COLS - 1, iy, fy);
            ix1 = (ix + 1 < GRID_ROWS) ? ix + 1 : ix;
            iy1 = (iy + 1 < GRID_COLS) ? iy + 1 : iy;
            near_row = longint'(65536 - fy) * sample_at(ix, iy) + longint'(fy) * sample_at(ix, iy1);
            far_row  = longint'(65536 - fy) * sample_at(ix1, iy) + longint'(fy) * sample_at(ix1, iy1);
            blend    = longint'(65536 - fx) * near_row + longint'(fx) * far_row;
            // Round half up from Q16.48 to Q16.16.
            blend    = (blend + 64'sh8000_0000) >>> 32;
            res.value   = blend[DATA_W-1:0];
            res.clamped = cx || cy;
            pending_q.push_back(res);
        endfunction

        task report(string msg);
            $display("tb mismatch: %s", msg);
            errors++;
        endtask

        task check_result(logic [DATA_W-1:0] value, logic clamped);
            interp_result_t want;
            if (pending_q.size() == 0)
            begin
                report($sformatf("result %h clamped %b with nothing pending", value, clamped));
                return;
            end
            want = pending_q.pop_front();
            if (value !== want.value)
                report($sformatf("interp_value %h, predicted %h", value, want.value));
            if (clamped !== want.clamped)
                report($sformatf("clamped %b, predicted %b", clamped, want.clamped));
        endtask

        function int pending();
            return pending_q.size();
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [S_TDATA_W-1:0]       s_axis_tdata = '0;
    logic                       s_axis_tuser = 1'b0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]       m_axis_tdata;
    logic                       m_axis_tuser;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [DATA_W-1:0]          cfg_data = '0;

    interp_scoreboard sb = new();
    bit          cell_written [GRID_ROWS][GRID_COLS];
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          items_sent = 0;
    bit          hold_armed = 1'b0;
    logic        rx_hold = 1'b0;
    int unsigned cycle_count = 0;

    grid_bilinear_interpolator #(
        .ROWS(GRID_ROWS),
        .COLS(GRID_COLS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
        m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);

    // Long receiver stall so the pipeline fills and backs up into the input.
    initial
    begin
        wait (hold_armed);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    task automatic send_request(cmd_t cmd, logic [IDX_IN_W-1:0] row, logic [IDX_IN_W-1:0] col,
                                logic [DATA_W-1:0] entry, logic [DATA_W-1:0] xc,
                                logic [DATA_W-1:0] yc);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {4'b0, yc, xc, entry, col, row};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_request(cmd, row, col, entry, xc, yc);
        items_sent++;
    endtask

    function automatic logic [DATA_W-1:0] random_sample();
        case ($urandom_range(7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return $urandom_range(32'h0004_0000);
            default: return $urandom;
        endcase
    endfunction

    task automatic write_cell(int r, int c, logic [DATA_W-1:0] value);
        send_request(CMD_WRITE, r[IDX_IN_W-1:0], c[IDX_IN_W-1:0], value, $urandom, $urandom);
        cell_written[r][c] = 1'b1;
    endtask

    task automatic ensure_cell(int r, int c);
        if (!cell_written[r][c])
            write_cell(r, c, random_sample());
    endtask

    // Every neighbor the block reads must hold a written sample, even one with zero weight.
    task automatic do_query(logic [DATA_W-1:0] xc, logic [DATA_W-1:0] yc);
        int ix, iy, fx, fy, ix1, iy1;
        bit flag;
        flag = sb.map_coord(xc, sb.x_origin, sb.x_scale, GRID_ROWS - 1, ix, fx);
        flag = sb.map_coord(yc, sb.y_origin, sb.y_scale, GRID_COLS - 1, iy, fy);
        ix1  = (ix + 1 < GRID_ROWS) ? ix + 1 : ix;
        iy1  = (iy + 1 < GRID_COLS) ? iy + 1 : iy;
        ensure_cell(ix, iy);
        ensure_cell(ix, iy1);
        ensure_cell(ix1, iy);
        ensure_cell(ix1, iy1);
        send_request(CMD_QUERY, IDX_IN_W'($urandom_range(63)), IDX_IN_W'($urandom_range(63)),
                     $urandom, xc, yc);
    endtask

    // Mostly coordinates that land inside the grid, plus edges, underflow and noise.
    function automatic logic [DATA_W-1:0] pick_coord(logic [DATA_W-1:0] origin,
                                                     logic [DATA_W-1:0] scale, int last);
        longint unsigned span;
        longint unsigned offset;
        longint unsigned sc;
        longint          target;
        span = last;
        span = span << 32;
        sc   = scale;
        if (scale == 0)
            span = 64'h1_0000_0000;
        else
            span = span / sc;
        if (span > 64'h1_0000_0000)
            span = 64'h1_0000_0000;
        case ($urandom_range(9))
            0:
            begin
                return $urandom;
            end
            1:
            begin
                target = longint'($signed(origin)) - longint'(1 + $urandom_range(255));
            end
            2:
            begin
                target = longint'($signed(origin)) + longint'(span) + $urandom_range(2) - 1;
            end
            default:
            begin
                offset = {$urandom, $urandom};
                offset = offset % (span + 1);
                target = longint'($signed(origin)) + longint'(offset);
            end
        endcase
        if (target < COORD_MIN || target > COORD_MAX)
            return $urandom;
        return target[DATA_W-1:0];
    endfunction

    task automatic write_reg(cfg_reg_t idx, logic [DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(idx, value);
    endtask

    task automatic configure(logic [DATA_W-1:0] xo, logic [DATA_W-1:0] xs,
                             logic [DATA_W-1:0] yo, logic [DATA_W-1:0] ys);
        write_reg(CFG_X_ORIGIN, xo);
        write_reg(CFG_X_SCALE, xs);
        write_reg(CFG_Y_ORIGIN, yo);
        write_reg(CFG_Y_SCALE, ys);
        cfg_valid <= 1'b0;
    endtask

    // Writes leave nothing to wait for, so a fixed tail covers any still in flight.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corners hold the sample extremes; queries hit the origin, mid cell, both edges.
        write_cell(0, 0, 32'h7FFF_FFFF);
        write_cell(0, 1, 32'h8000_0000);
        write_cell(1, 0, 32'h8000_0000);
        write_cell(1, 1, 32'h7FFF_FFFF);
        write_cell(63, 63, 32'h7FFF_FFFF);
        write_cell(63, 62, 32'h0001_0000);
        write_cell(62, 63, 32'hFFFF_FFFF);
        write_cell(62, 62, 32'h0000_0000);
        do_query(32'h0000_0000, 32'h0000_0000);
        do_query(32'h0000_0208, 32'h0000_0208);
        do_query(32'h0000_0208, 32'h0000_0000);
        do_query(32'hFFFF_FFFF, 32'h0000_0104);
        do_query(32'h0001_0000, 32'h0001_0000);
        do_query(32'h0001_0001, 32'h0001_0000);
        do_query(32'h7FFF_FFFF, 32'h8000_0000);
        do_query(32'h0000_FFFF, 32'h0000_FFFF);
        do_query(32'h0001_0000, 32'h0000_0208);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase != 0)
                settle();
            case (phase)
                1: configure(32'h8000_0000, 32'h0001_0000, 32'h7FFF_FFFF, 32'h0002_0000);
                2: configure(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
                3: configure(32'hFFF0_0000, 32'h000A_8000, 32'h0005_0000, 32'h0000_1234);
                4: configure(32'h0000_0000, 32'h0000_0001, $urandom, SCALE_RESET);
                5: configure($urandom, $urandom_range(32'h0040_0000, 32'h0000_4000),
                             $urandom, $urandom_range(32'h0040_0000, 32'h0000_4000));
                default: ;
            endcase
            case (phase % 3)
                0:
                begin
                    tx_idle_pct = 25;
                    rx_idle_pct = 81;
                end
                1:
                begin
                    tx_idle_pct = 81;
                    rx_idle_pct = 25;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            if (phase == 2)
                hold_armed = 1'b1;
            // Sample fills for neighbors count toward the phase budget.
            while (items_sent < (phase + 1) * ITEMS_PER_PHASE)
            begin
                if ($urandom_range(99) < 20)
                    write_cell($urandom_range(GRID_ROWS - 1), $urandom_range(GRID_COLS - 1),
                               random_sample());
                else
                    do_query(pick_coord(sb.x_origin, sb.x_scale, GRID_ROWS - 1),
                             pick_coord(sb.y_origin, sb.y_scale, GRID_COLS - 1));
            end
        end
        settle();

        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
